### rtl/balanced_gadget_decompose_defines.svh
// assertion helpers for the decomposer, clocked on clk, off during reset
`ifndef BALANCED_GADGET_DECOMPOSE_DEFINES_SVH
`define BALANCED_GADGET_DECOMPOSE_DEFINES_SVH

// same-cycle implication
`define BGD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bgd_pkg.sv
`timescale 1ns / 1ps
package bgd_pkg;

  localparam int DEF_VALUE_BITS     = 32;
  localparam int DEF_MAX_DIGITS     = 16;
  localparam int DEF_MAX_RADIX_BITS = 16;

  localparam int RADIX_W    = 5;
  localparam int WIDTH_W    = 6;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int DIGIT_W    = 16;
  localparam int IDX_W      = 4;
  localparam int SPAN_W     = 10;
  localparam int POS_W      = 13;

  localparam logic [RADIX_W-1:0] RADIX_RST = 5'd4;
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 6'd32;
  localparam logic [COUNT_W-1:0] COUNT_RST = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX = 2'd0,
    REG_WIDTH = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [COUNT_W-1:0] count;
  } digit_cfg_t;

endpackage

### rtl/bgd_front.sv
`timescale 1ns / 1ps
module bgd_front #(
  parameter int VALUE_BITS     = bgd_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS     = bgd_pkg::DEF_MAX_DIGITS,
  parameter int MAX_RADIX_BITS = bgd_pkg::DEF_MAX_RADIX_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [bgd_pkg::RADIX_W-1:0]        radix_bits,
  input  logic [bgd_pkg::WIDTH_W-1:0]        width_bits,
  input  logic [bgd_pkg::COUNT_W-1:0]        digit_count,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [VALUE_BITS-1:0]       in_value,
  input  logic                               take,
  output logic                               f_valid,
  output logic [VALUE_BITS-1:0]              f_word,
  output logic signed [bgd_pkg::POS_W-1:0]   f_pos0,
  output bgd_pkg::digit_cfg_t                dcfg
);
  import bgd_pkg::*;

  logic [RADIX_W-1:0]           radix_c;
  logic [WIDTH_W-1:0]           width_c;
  logic [COUNT_W-1:0]           count_c;
  logic [SPAN_W-1:0]            span;
  logic signed [POS_W-1:0]      pos0;
  logic [VALUE_BITS-1:0]        wmask;
  logic [VALUE_BITS-1:0]        word0;
  logic [VALUE_BITS-1:0]        rnd;
  logic [VALUE_BITS-1:0]        word_nxt;
  logic                         f_valid_r;
  logic [VALUE_BITS-1:0]        word_r;
  logic signed [POS_W-1:0]      pos0_r;
  logic                         acc;

  always_comb begin
    if (radix_bits == '0) begin
      radix_c = RADIX_W'(1);
    end else if (int'(radix_bits) > MAX_RADIX_BITS) begin
      radix_c = RADIX_W'(MAX_RADIX_BITS);
    end else begin
      radix_c = radix_bits;
    end
    if (width_bits == '0) begin
      width_c = WIDTH_W'(1);
    end else if (int'(width_bits) > VALUE_BITS) begin
      width_c = WIDTH_W'(VALUE_BITS);
    end else begin
      width_c = width_bits;
    end
    if (digit_count == '0) begin
      count_c = COUNT_W'(1);
    end else if (int'(digit_count) > MAX_DIGITS) begin
      count_c = COUNT_W'(MAX_DIGITS);
    end else begin
      count_c = digit_count;
    end
  end

  assign span  = SPAN_W'(count_c) * SPAN_W'(radix_c);
  assign pos0  = $signed(POS_W'(width_c)) - $signed(POS_W'(span));
  assign wmask = {VALUE_BITS{1'b1}} >> (VALUE_BITS - int'(width_c));
  assign word0 = $unsigned(in_value) & wmask;

  // round to the kept digits when low bits are dropped
  always_comb begin
    rnd      = '0;
    word_nxt = word0;
    if (pos0 > 0) begin
      rnd      = VALUE_BITS'(1) << (int'(pos0) - 1);
      word_nxt = (word0 + rnd) & wmask;
    end
  end

  assign acc      = in_valid && !in_stall;
  assign in_stall = f_valid_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (acc) begin
      f_valid_r <= 1'b1;
    end else if (take) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      word_r <= word_nxt;
      pos0_r <= pos0;
    end
  end

  assign f_valid     = f_valid_r;
  assign f_word      = word_r;
  assign f_pos0      = pos0_r;
  assign dcfg.radix  = radix_c;
  assign dcfg.count  = count_c;

endmodule

### rtl/bgd_cell.sv
`timescale 1ns / 1ps
module bgd_cell #(
  parameter int VALUE_BITS     = bgd_pkg::DEF_VALUE_BITS,
  parameter int MAX_RADIX_BITS = bgd_pkg::DEF_MAX_RADIX_BITS,
  parameter int INDEX          = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               load,
  input  bgd_pkg::digit_cfg_t                dcfg,
  input  logic [VALUE_BITS-1:0]              word,
  input  logic signed [bgd_pkg::POS_W-1:0]   pos0,
  input  logic                               nb_valid,
  input  logic [MAX_RADIX_BITS-1:0]          nb_win,
  input  logic [bgd_pkg::IDX_W-1:0]          nb_idx,
  input  logic                               nb_last,
  output logic                               valid,
  output logic [MAX_RADIX_BITS-1:0]          win,
  output logic [bgd_pkg::IDX_W-1:0]          idx,
  output logic                               last
);
  import bgd_pkg::*;

  localparam int EXT_W = VALUE_BITS + MAX_RADIX_BITS;

  logic signed [POS_W-1:0]      pos_i;
  logic [POS_W-1:0]             nsh;
  logic [MAX_RADIX_BITS-1:0]    dmask;
  logic [EXT_W-1:0]             ext;
  logic [MAX_RADIX_BITS-1:0]    ld_win;
  logic                         ld_valid;
  logic [6:0]                   ld_pos;
  logic                         valid_r;
  logic [MAX_RADIX_BITS-1:0]    win_r;
  logic [IDX_W-1:0]             idx_r;
  logic                         last_r;

  assign pos_i = pos0 + $signed(POS_W'(INDEX) * POS_W'(dcfg.radix));
  assign nsh   = POS_W'(-pos_i);
  assign dmask = {MAX_RADIX_BITS{1'b1}} >> (MAX_RADIX_BITS - int'(dcfg.radix));
  assign ext   = {{MAX_RADIX_BITS{1'b0}}, word};

  // window of this digit; bits below the word read as zero
  always_comb begin
    if (!pos_i[POS_W-1]) begin
      ld_win = MAX_RADIX_BITS'(ext >> $unsigned(pos_i)) & dmask;
    end else if (nsh < POS_W'(dcfg.radix)) begin
      ld_win = MAX_RADIX_BITS'(ext << nsh) & dmask;
    end else begin
      ld_win = '0;
    end
  end

  assign ld_valid = (7'(INDEX) < 7'(dcfg.count));
  assign ld_pos   = 7'(dcfg.count) - 7'(INDEX) - 7'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= ld_valid;
    end else if (adv) begin
      valid_r <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win_r  <= ld_win;
      idx_r  <= ld_pos[IDX_W-1:0];
      last_r <= (ld_pos == 7'd0);
    end else if (adv) begin
      win_r  <= nb_win;
      idx_r  <= nb_idx;
      last_r <= nb_last;
    end
  end

  assign valid = valid_r;
  assign win   = win_r;
  assign idx   = idx_r;
  assign last  = last_r;

endmodule

### rtl/balanced_gadget_decompose.sv
`timescale 1ns / 1ps
// path: an accepted transaction is registered in bgd_front, then loaded into the digit cells; cell 0 drives the output
// throughput: one digit per cycle while out_stall is low, set by the single output port of the
//   digit cell chain; bgd_front can hold the next input value while the chain drains the last one
// reset: synchronous active-low rst_n clears all valid state and sets
//   radix_bits = 4, width_bits = 32, digit_count = 4
`include "balanced_gadget_decompose_defines.svh"
module balanced_gadget_decompose #(
  parameter int VALUE_BITS     = bgd_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS     = bgd_pkg::DEF_MAX_DIGITS,
  parameter int MAX_RADIX_BITS = bgd_pkg::DEF_MAX_RADIX_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bgd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [VALUE_BITS-1:0]        in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bgd_pkg::DIGIT_W-1:0]  out_digit,
  output logic [bgd_pkg::IDX_W-1:0]           out_digit_index,
  output logic                                out_last
);
  import bgd_pkg::*;

  localparam int DW = MAX_RADIX_BITS + 2;

  logic [RADIX_W-1:0]           radix_r;
  logic [WIDTH_W-1:0]           width_r;
  logic [COUNT_W-1:0]           count_r;
  logic                         f_valid;
  logic [VALUE_BITS-1:0]        f_word;
  logic signed [POS_W-1:0]      f_pos0;
  digit_cfg_t                   dcfg;
  logic                         adv;
  logic                         load;
  logic                         out_acc;
  logic                         carry_r;
  logic                         carry_nxt;
  logic [MAX_DIGITS:0]          cv;
  logic [MAX_RADIX_BITS-1:0]    cw [MAX_DIGITS+1];
  logic [IDX_W-1:0]             ci [MAX_DIGITS+1];
  logic [MAX_DIGITS:0]          cl;
  logic [MAX_RADIX_BITS:0]      dsum;
  logic [MAX_RADIX_BITS:0]      half;
  logic [DW-1:0]                base;
  logic signed [DW-1:0]         dv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RST;
      width_r <= WIDTH_RST;
      count_r <= COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIX: radix_r <= cfg_wdata[RADIX_W-1:0];
        REG_WIDTH: width_r <= cfg_wdata[WIDTH_W-1:0];
        REG_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bgd_front #(
    .VALUE_BITS     (VALUE_BITS),
    .MAX_DIGITS     (MAX_DIGITS),
    .MAX_RADIX_BITS (MAX_RADIX_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .radix_bits  (radix_r),
    .width_bits  (width_r),
    .digit_count (count_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value    (in_value),
    .take        (load),
    .f_valid     (f_valid),
    .f_word      (f_word),
    .f_pos0      (f_pos0),
    .dcfg        (dcfg)
  );

  // chain shifts toward cell 0 whenever the output slot frees up
  assign out_acc = cv[0] && !out_stall;
  assign adv     = !cv[0] || !out_stall;
  assign load    = adv && !cv[1] && f_valid;

  assign cv[MAX_DIGITS] = 1'b0;
  assign cw[MAX_DIGITS] = '0;
  assign ci[MAX_DIGITS] = '0;
  assign cl[MAX_DIGITS] = 1'b0;

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
    bgd_cell #(
      .VALUE_BITS     (VALUE_BITS),
      .MAX_RADIX_BITS (MAX_RADIX_BITS),
      .INDEX          (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .load     (load),
      .dcfg     (dcfg),
      .word     (f_word),
      .pos0     (f_pos0),
      .nb_valid (cv[g+1]),
      .nb_win   (cw[g+1]),
      .nb_idx   (ci[g+1]),
      .nb_last  (cl[g+1]),
      .valid    (cv[g]),
      .win      (cw[g]),
      .idx      (ci[g]),
      .last     (cl[g])
    );
  end

  // balanced fold with carry from the previous digit
  assign dsum = (MAX_RADIX_BITS+1)'(cw[0]) + (MAX_RADIX_BITS+1)'(carry_r);
  assign half = (MAX_RADIX_BITS+1)'(1) << (int'(dcfg.radix) - 1);
  assign base = DW'(1) << dcfg.radix;

  always_comb begin
    if (dsum >= half) begin
      dv        = $signed(DW'(dsum) - base);
      carry_nxt = 1'b1;
    end else begin
      dv        = $signed(DW'(dsum));
      carry_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= 1'b0;
    end else if (out_acc) begin
      carry_r <= cl[0] ? 1'b0 : carry_nxt;
    end
  end

  assign out_valid       = cv[0];
  assign out_digit       = DIGIT_W'(dv);
  assign out_digit_index = ci[0];
  assign out_last        = cl[0];

  `BGD_ASSERT_IMPL(a_last_is_top, out_valid && out_last, out_digit_index == '0, "last digit not at index 0")
  `BGD_ASSERT_IMPL(a_next_queued, out_valid && !out_last, cv[1], "digit chain broken before last")
  `BGD_ASSERT_NEXT(a_carry_clear, out_acc && out_last, !carry_r, "carry leaks into next value")
  `BGD_ASSERT_NEXT(a_contiguous, out_acc && !out_last, out_valid, "gap inside one value")

endmodule
